/* sv/mmrs_pkg.sv */
// Shared types, widths and codes for the motor mode ramp sequencer.
`timescale 1ns / 1ps
package mmrs_pkg;

    localparam int MAX_MOTORS     = 8;
    localparam int NUM_MOTORS_DEF = 8;

    localparam int TGT_W     = 18;
    localparam int STEP_W    = 4;
    localparam int CNT_W     = 16;
    localparam int HOLD_W    = 17;
    localparam int PROD_W    = STEP_W + CNT_W;
    localparam int MAG_W     = PROD_W + 2;
    localparam int CODE_W    = 8;
    localparam int FLAG_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = HOLD_W;

    localparam logic [STEP_W-1:0] RAMP_STEP_RST = STEP_W'(4);
    localparam logic [CNT_W-1:0]  RAMP_LEN_RST  = CNT_W'(4250);
    localparam logic [HOLD_W-1:0] HOLD_POS_RST  = HOLD_W'(17000);

    // Bit positions inside the mode flag word.
    localparam int FLAG_READY  = 0;
    localparam int FLAG_RUN    = 1;
    localparam int FLAG_STOP   = 2;
    localparam int FLAG_PARK   = 3;
    localparam int FLAG_UNLOCK = 4;

    typedef enum logic [CODE_W-1:0] {
        MODE_CLR_READY = 8'd1,
        MODE_UNLOCK    = 8'd4,
        MODE_WALK      = 8'd13,
        MODE_STOP      = 8'd14,
        MODE_READY     = 8'd15,
        MODE_PARK      = 8'd16
    } mode_code_t;

    typedef enum logic [1:0] {
        PH_STAND  = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_PARKED = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        LANE_ZERO,
        LANE_SET,
        LANE_GAIT,
        LANE_HOLD
    } lane_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP = 2'd0,
        CFG_RAMP_LEN  = 2'd1,
        CFG_HOLD_POS  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                    load;
        lane_op_t                op;
        logic signed [MAG_W-1:0] mag;
    } lane_cmd_t;

endpackage

/* sv/mmrs_lane.sv */
// One motor lane: applies the shared command with the lane's sign and saturates.
`timescale 1ns / 1ps
module mmrs_lane
    import mmrs_pkg::*;
#(
    parameter bit NEGATE = 1'b1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lane_cmd_t               lane_cmd,
    input  logic signed [TGT_W-1:0] gait_target,
    output logic signed [TGT_W-1:0] drive
);

    localparam logic signed [MAG_W-1:0] SAT_HI = MAG_W'((2 ** (TGT_W - 1)) - 1);
    localparam logic signed [MAG_W-1:0] SAT_LO = -SAT_HI - MAG_W'(1);

    logic signed [TGT_W-1:0] held_reg;
    logic signed [TGT_W-1:0] held_next;
    logic signed [MAG_W-1:0] signed_mag;
    logic signed [TGT_W-1:0] sat_val;

    assign signed_mag = NEGATE ? -lane_cmd.mag : lane_cmd.mag;

    always_comb begin
        if (signed_mag > SAT_HI) begin
            sat_val = SAT_HI[TGT_W-1:0];
        end else if (signed_mag < SAT_LO) begin
            sat_val = SAT_LO[TGT_W-1:0];
        end else begin
            sat_val = signed_mag[TGT_W-1:0];
        end
    end

    always_comb begin
        held_next = held_reg;
        if (lane_cmd.load) begin
            unique case (lane_cmd.op)
                LANE_ZERO: held_next = '0;
                LANE_SET:  held_next = sat_val;
                LANE_GAIT: held_next = gait_target;
                LANE_HOLD: held_next = held_reg;
                default:   held_next = held_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

    assign drive = held_reg;

endmodule

/* sv/mmrs_ctrl.sv */
// Mode flags, phase sequencer and ramp counter; issues one command to all lanes.
`timescale 1ns / 1ps
module mmrs_ctrl
    import mmrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tick_fire,
    input  logic              mode_fire,
    input  logic [CODE_W-1:0] mode_code,
    input  logic [STEP_W-1:0] ramp_step,
    input  logic [CNT_W-1:0]  ramp_length,
    input  logic [HOLD_W-1:0] hold_position,
    output lane_cmd_t         lane_cmd,
    output logic [FLAG_W-1:0] flags,
    output phase_t            phase
);

    logic [FLAG_W-1:0] flags_reg;
    logic [FLAG_W-1:0] flags_next;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic                    unlocked;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    ramp_done;
    logic                    stand_ramp;
    logic                    to_active;
    logic [CNT_W-1:0]        park_base;
    logic [CNT_W-1:0]        park_inc;
    logic                    park_done;
    logic                    parking;
    logic [CNT_W-1:0]        mul_cnt;
    logic [PROD_W-1:0]       product;
    logic signed [MAG_W-1:0] hold_s;
    logic signed [MAG_W-1:0] prod_s;

    assign unlocked   = flags_reg[FLAG_UNLOCK];
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign ramp_done  = (cnt_inc >= ramp_length);
    assign stand_ramp = (phase_reg == PH_STAND) && !ramp_done;
    // A stand-up ramp that ends on this tick falls into the active phase at once.
    assign to_active  = (phase_reg == PH_ACTIVE) || ((phase_reg == PH_STAND) && ramp_done);
    assign park_base  = (phase_reg == PH_STAND) ? '0 : cnt_reg;
    assign park_inc   = park_base + CNT_W'(1);
    assign park_done  = (park_inc >= ramp_length);
    assign parking    = !flags_reg[FLAG_STOP] && flags_reg[FLAG_PARK];

    assign mul_cnt = stand_ramp ? cnt_inc : park_inc;
    assign product = PROD_W'(ramp_step) * PROD_W'(mul_cnt);
    assign hold_s  = $signed(MAG_W'(hold_position));
    assign prod_s  = $signed(MAG_W'(product));

    always_comb begin
        flags_next = flags_reg;
        if (mode_fire) begin
            unique case (mode_code)
                MODE_CLR_READY: flags_next[FLAG_READY] = 1'b0;
                MODE_UNLOCK:    flags_next = FLAG_W'(1) << FLAG_UNLOCK;
                MODE_WALK:      flags_next = (flags_reg & (FLAG_W'(1) << FLAG_UNLOCK))
                                           | (FLAG_W'(1) << FLAG_RUN);
                MODE_STOP:      flags_next = (flags_reg & (FLAG_W'(1) << FLAG_UNLOCK))
                                           | (FLAG_W'(1) << FLAG_STOP);
                MODE_READY:     flags_next = (flags_reg & (FLAG_W'(1) << FLAG_UNLOCK))
                                           | (FLAG_W'(1) << FLAG_READY);
                MODE_PARK:      flags_next = (flags_reg & (FLAG_W'(1) << FLAG_UNLOCK))
                                           | (FLAG_W'(1) << FLAG_PARK);
                default:        flags_next = flags_reg;
            endcase
        end
    end

    // Next phase and ramp count.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (tick_fire && unlocked) begin
            if (stand_ramp) begin
                cnt_next = cnt_inc;
            end else if (to_active) begin
                phase_next = PH_ACTIVE;
                cnt_next   = park_base;
                if (parking) begin
                    if (park_done) begin
                        cnt_next   = '0;
                        phase_next = PH_PARKED;
                    end else begin
                        cnt_next = park_inc;
                    end
                end
            end
        end
    end

    // Lane command for this tick.
    always_comb begin
        lane_cmd.load = tick_fire;
        lane_cmd.op   = LANE_HOLD;
        lane_cmd.mag  = prod_s;
        if (!unlocked) begin
            lane_cmd.op = LANE_ZERO;
        end else if (stand_ramp) begin
            lane_cmd.op = LANE_SET;
        end else if (to_active) begin
            if (flags_reg[FLAG_STOP]) begin
                lane_cmd.op  = LANE_SET;
                lane_cmd.mag = hold_s;
            end else if (flags_reg[FLAG_PARK]) begin
                lane_cmd.op  = LANE_SET;
                lane_cmd.mag = hold_s - prod_s;
            end else begin
                lane_cmd.op = LANE_GAIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            phase_reg <= PH_STAND;
            cnt_reg   <= '0;
        end else begin
            flags_reg <= flags_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign flags = flags_reg;
    assign phase = phase_reg;

endmodule

/* sv/motor_mode_ramp_sequencer.sv */
// Top level of the motor mode ramp sequencer: config registers, lanes and output stage.
//
//  channel | direction | ports                                   | word
//  s_      | in        | s_valid/s_ready, command, code, targets | one mode code or tick
//  m_      | out       | m_valid/m_ready, drives, flags, phase   | one result per tick
//  cfg_    | in        | cfg_valid/cfg_ready, index, data        | one register write
//
// A tick's result is registered and shown the next cycle. The lanes and the output
// register form one stage, so a new word is taken in the cycle the pending result is
// taken, giving one word per cycle sustained while m_ready stays high.
// Reset clears flags, phase, ramp count and targets and loads the register defaults.
// A stalled result blocks s_ready; configuration writes are always taken.
`timescale 1ns / 1ps
module motor_mode_ramp_sequencer
    import mmrs_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [CODE_W-1:0]       s_mode_code,
    input  logic signed [TGT_W-1:0] s_gait_target_m1,
    input  logic signed [TGT_W-1:0] s_gait_target_m2,
    input  logic signed [TGT_W-1:0] s_gait_target_m3,
    input  logic signed [TGT_W-1:0] s_gait_target_m4,
    input  logic signed [TGT_W-1:0] s_gait_target_m5,
    input  logic signed [TGT_W-1:0] s_gait_target_m6,
    input  logic signed [TGT_W-1:0] s_gait_target_m7,
    input  logic signed [TGT_W-1:0] s_gait_target_m8,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [TGT_W-1:0] m_drive_m1,
    output logic signed [TGT_W-1:0] m_drive_m2,
    output logic signed [TGT_W-1:0] m_drive_m3,
    output logic signed [TGT_W-1:0] m_drive_m4,
    output logic signed [TGT_W-1:0] m_drive_m5,
    output logic signed [TGT_W-1:0] m_drive_m6,
    output logic signed [TGT_W-1:0] m_drive_m7,
    output logic signed [TGT_W-1:0] m_drive_m8,
    output logic [FLAG_W-1:0]       m_mode_flags,
    output logic [1:0]              m_phase,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data
);

    logic [STEP_W-1:0] ramp_step_reg;
    logic [CNT_W-1:0]  ramp_len_reg;
    logic [HOLD_W-1:0] hold_pos_reg;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [FLAG_W-1:0] m_flags_reg;

    logic              accept;
    logic              tick_fire;
    logic              mode_fire;
    lane_cmd_t         lane_cmd;
    logic [FLAG_W-1:0] flags;
    phase_t            phase;

    logic signed [TGT_W-1:0] gait [MAX_MOTORS];
    logic signed [TGT_W-1:0] drive [MAX_MOTORS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg <= RAMP_STEP_RST;
            ramp_len_reg  <= RAMP_LEN_RST;
            hold_pos_reg  <= HOLD_POS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RAMP_STEP: ramp_step_reg <= cfg_data[STEP_W-1:0];
                CFG_RAMP_LEN:  ramp_len_reg  <= cfg_data[CNT_W-1:0];
                CFG_HOLD_POS:  hold_pos_reg  <= cfg_data[HOLD_W-1:0];
                default:       ;
            endcase
        end
    end

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign tick_fire = accept && !s_command;
    assign mode_fire = accept && s_command;

    mmrs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_fire     (tick_fire),
        .mode_fire     (mode_fire),
        .mode_code     (s_mode_code),
        .ramp_step     (ramp_step_reg),
        .ramp_length   (ramp_len_reg),
        .hold_position (hold_pos_reg),
        .lane_cmd      (lane_cmd),
        .flags         (flags),
        .phase         (phase)
    );

    assign gait[0] = s_gait_target_m1;
    assign gait[1] = s_gait_target_m2;
    assign gait[2] = s_gait_target_m3;
    assign gait[3] = s_gait_target_m4;
    assign gait[4] = s_gait_target_m5;
    assign gait[5] = s_gait_target_m6;
    assign gait[6] = s_gait_target_m7;
    assign gait[7] = s_gait_target_m8;

    // Motor one, three, ... run negative; the other motors run positive.
    for (genvar g = 0; g < MAX_MOTORS; g++) begin : g_lane
        if (g < NUM_MOTORS) begin : g_used
            mmrs_lane #(
                .NEGATE ((g % 2) == 0)
            ) u_lane (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .lane_cmd    (lane_cmd),
                .gait_target (gait[g]),
                .drive       (drive[g])
            );
        end else begin : g_unused
            assign drive[g] = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (tick_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Flags can change under a pending result, so the result keeps its own copy.
    always_ff @(posedge aclk) begin
        if (tick_fire) begin
            m_flags_reg <= flags;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mode_flags = m_flags_reg;
    assign m_phase      = phase;
    assign m_drive_m1   = drive[0];
    assign m_drive_m2   = drive[1];
    assign m_drive_m3   = drive[2];
    assign m_drive_m4   = drive[3];
    assign m_drive_m5   = drive[4];
    assign m_drive_m6   = drive[5];
    assign m_drive_m7   = drive[6];
    assign m_drive_m8   = drive[7];

endmodule

/* sv/mmrs_checker.sv */
// Port-level checks for the motor mode ramp sequencer and their binding.
`timescale 1ns / 1ps
module mmrs_checker
    import mmrs_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_command,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [TGT_W-1:0] m_drive_m1,
    input logic signed [TGT_W-1:0] m_drive_m2,
    input logic [FLAG_W-1:0]       m_mode_flags,
    input logic [1:0]              m_phase
);

    // A held result word keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_m1) && $stable(m_mode_flags))
        else $error("result word changed while stalled");

    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_command |=> m_valid)
        else $error("accepted tick gave no result");

    a_locked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_mode_flags[FLAG_UNLOCK] |-> m_drive_m1 == '0 && m_drive_m2 == '0)
        else $error("locked result with nonzero target");

    a_stand_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode_flags[FLAG_UNLOCK] && m_phase == PH_STAND
        |-> m_drive_m1 <= 0 && m_drive_m2 >= 0)
        else $error("stand-up ramp with wrong target sign");

    a_parked_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        m_phase == PH_PARKED |=> m_phase == PH_PARKED)
        else $error("left the parked phase");

endmodule

bind motor_mode_ramp_sequencer mmrs_checker u_mmrs_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the motor mode ramp sequencer with its own drive-target predictor.
`timescale 1ns / 1ps
module tb_top;
    import mmrs_pkg::*;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MODE = 1'b1;

    localparam logic [CODE_W-1:0]    CODE_IGN_LO = 8'd0;
    localparam logic [CODE_W-1:0]    CODE_IGN_HI = 8'd255;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    localparam logic [TGT_W-1:0] TGT_MAX = 18'h1FFFF;
    localparam logic [TGT_W-1:0] TGT_MIN = 18'h20000;

    localparam logic [FLAG_W-1:0] FL_NONE   = '0;
    localparam logic [FLAG_W-1:0] FL_READY  = FLAG_W'(1) << FLAG_READY;
    localparam logic [FLAG_W-1:0] FL_RUN    = FLAG_W'(1) << FLAG_RUN;
    localparam logic [FLAG_W-1:0] FL_STOP   = FLAG_W'(1) << FLAG_STOP;
    localparam logic [FLAG_W-1:0] FL_PARK   = FLAG_W'(1) << FLAG_PARK;
    localparam logic [FLAG_W-1:0] FL_UNLOCK = FLAG_W'(1) << FLAG_UNLOCK;

    localparam int DIR_ROWS        = 25;
    localparam int SWEEP_TICKS     = 250;
    localparam int SEG_WORDS       = 400;
    localparam int TAIL_WORDS      = 40;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef logic [MAX_MOTORS-1:0][TGT_W-1:0] target_set_t;

    typedef struct packed {
        target_set_t       drive;
        logic [FLAG_W-1:0] flags;
        logic [1:0]        phase;
    } drive_word_t;

    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_MAX,
        FILL_MIN,
        FILL_RAND
    } fill_t;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] code;
        fill_t             fill;
        logic              chk;
        logic [TGT_W-1:0]  mag;
        logic [FLAG_W-1:0] flags;
    } dir_row_t;

    logic aclk;
    logic aresetn;

    logic                    s_valid;
    logic                    s_ready;
    logic                    s_command;
    logic [CODE_W-1:0]       s_mode_code;
    logic signed [TGT_W-1:0] s_gait_target_m1, s_gait_target_m2, s_gait_target_m3;
    logic signed [TGT_W-1:0] s_gait_target_m4, s_gait_target_m5, s_gait_target_m6;
    logic signed [TGT_W-1:0] s_gait_target_m7, s_gait_target_m8;

    logic                    m_valid;
    logic                    m_ready;
    logic signed [TGT_W-1:0] m_drive_m1, m_drive_m2, m_drive_m3, m_drive_m4;
    logic signed [TGT_W-1:0] m_drive_m5, m_drive_m6, m_drive_m7, m_drive_m8;
    logic [FLAG_W-1:0]       m_mode_flags;
    logic [1:0]              m_phase;

    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;

    // Predictor state and its copy of the configuration registers.
    logic [FLAG_W-1:0] mode_flags_q = '0;
    phase_t            phase_q      = PH_STAND;
    logic [CNT_W-1:0]  ramp_cnt_q   = '0;
    target_set_t       held_q       = '0;
    logic [STEP_W-1:0] step_c       = RAMP_STEP_RST;
    logic [CNT_W-1:0]  len_c        = RAMP_LEN_RST;
    logic [HOLD_W-1:0] hold_c       = HOLD_POS_RST;

    drive_word_t pending_drives[$];

    // Typed expectation of the directed word now on the input channel.
    bit          row_has_exp = 0;
    drive_word_t row_exp     = '0;

    bit tx_idle       = 0;
    bit rx_idle       = 0;
    bit hold_off_req  = 0;
    int fail_count    = 0;
    int mode_words    = 0;
    int tick_words    = 0;
    int results_seen  = 0;
    int cycle_count   = 0;

    motor_mode_ramp_sequencer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_mode_code      (s_mode_code),
        .s_gait_target_m1 (s_gait_target_m1),
        .s_gait_target_m2 (s_gait_target_m2),
        .s_gait_target_m3 (s_gait_target_m3),
        .s_gait_target_m4 (s_gait_target_m4),
        .s_gait_target_m5 (s_gait_target_m5),
        .s_gait_target_m6 (s_gait_target_m6),
        .s_gait_target_m7 (s_gait_target_m7),
        .s_gait_target_m8 (s_gait_target_m8),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_m1       (m_drive_m1),
        .m_drive_m2       (m_drive_m2),
        .m_drive_m3       (m_drive_m3),
        .m_drive_m4       (m_drive_m4),
        .m_drive_m5       (m_drive_m5),
        .m_drive_m6       (m_drive_m6),
        .m_drive_m7       (m_drive_m7),
        .m_drive_m8       (m_drive_m8),
        .m_mode_flags     (m_mode_flags),
        .m_phase          (m_phase),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Magnitude with the motor's sign: motors one, three, ... go negative.
    function automatic target_set_t spread(input longint mag);
        target_set_t v;
        longint      s;
        for (int i = 0; i < MAX_MOTORS; i++) begin
            s = (i % 2) ? mag : -mag;
            if (s > 131071) s = 131071;
            else if (s < -131072) s = -131072;
            v[i] = s[TGT_W-1:0];
        end
        return v;
    endfunction

    task automatic compute_drive_word(input logic cmd, input logic [CODE_W-1:0] code,
                                      input target_set_t gait, output bit has_word,
                                      output drive_word_t w);
        bit done;
        has_word = 0;
        w        = '0;
        if (cmd == CMD_MODE) begin
            case (code)
                MODE_CLR_READY: mode_flags_q = mode_flags_q & ~FL_READY;
                MODE_UNLOCK:    mode_flags_q = FL_UNLOCK;
                MODE_WALK:      mode_flags_q = (mode_flags_q & FL_UNLOCK) | FL_RUN;
                MODE_STOP:      mode_flags_q = (mode_flags_q & FL_UNLOCK) | FL_STOP;
                MODE_READY:     mode_flags_q = (mode_flags_q & FL_UNLOCK) | FL_READY;
                MODE_PARK:      mode_flags_q = (mode_flags_q & FL_UNLOCK) | FL_PARK;
                default: ;
            endcase
            return;
        end
        if (!mode_flags_q[FLAG_UNLOCK]) begin
            held_q = '0;
        end else begin
            if (phase_q == PH_STAND) begin
                ramp_cnt_q = ramp_cnt_q + 1'b1;
                done       = (ramp_cnt_q >= len_c);
                held_q     = spread(longint'(step_c) * longint'(ramp_cnt_q));
                if (done) begin
                    ramp_cnt_q = '0;
                    phase_q    = PH_ACTIVE;
                end
            end
            // The stand-up ramp may end and hand over to the active phase in one tick.
            if (phase_q == PH_ACTIVE) begin
                if (mode_flags_q[FLAG_STOP]) begin
                    held_q = spread(longint'(hold_c));
                end else if (mode_flags_q[FLAG_PARK]) begin
                    ramp_cnt_q = ramp_cnt_q + 1'b1;
                    done       = (ramp_cnt_q >= len_c);
                    held_q     = spread(longint'(hold_c) -
                                        longint'(step_c) * longint'(ramp_cnt_q));
                    if (done) begin
                        ramp_cnt_q = '0;
                        phase_q    = PH_PARKED;
                    end
                end else begin
                    held_q = gait;
                end
            end
        end
        w.drive  = held_q;
        w.flags  = mode_flags_q;
        w.phase  = phase_q;
        has_word = 1;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Scoreboard: results are compared before the word accepted at the same edge is queued.
    always @(posedge aclk) begin
        drive_word_t want;
        drive_word_t pred;
        target_set_t got_drv;
        target_set_t gait_in;
        bit          has;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                got_drv = {m_drive_m8, m_drive_m7, m_drive_m6, m_drive_m5,
                           m_drive_m4, m_drive_m3, m_drive_m2, m_drive_m1};
                if (pending_drives.size() == 0) begin
                    fail_count++;
                    $error("result word arrived with nothing expected");
                end else begin
                    want = pending_drives.pop_front();
                    for (int i = 0; i < MAX_MOTORS; i++)
                        check_field($sformatf("drive_m%0d", i + 1),
                                    $signed(want.drive[i]), $signed(got_drv[i]));
                    check_field("mode_flags", want.flags, m_mode_flags);
                    check_field("phase", want.phase, m_phase);
                end
            end
            if (s_valid && s_ready) begin
                gait_in = {s_gait_target_m8, s_gait_target_m7, s_gait_target_m6,
                           s_gait_target_m5, s_gait_target_m4, s_gait_target_m3,
                           s_gait_target_m2, s_gait_target_m1};
                compute_drive_word(s_command, s_mode_code, gait_in, has, pred);
                if (s_command == CMD_MODE) mode_words++;
                else tick_words++;
                if (has) pending_drives.push_back(row_has_exp ? row_exp : pred);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RAMP_STEP: step_c = cfg_data[STEP_W-1:0];
                    CFG_RAMP_LEN:  len_c  = cfg_data[CNT_W-1:0];
                    CFG_HOLD_POS:  hold_c = cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off counted here.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_req = 0;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic push_word(input logic cmd, input logic [CODE_W-1:0] code,
                             input target_set_t gait, input bit chk,
                             input drive_word_t exp_word);
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge aclk);
        end
        @(negedge aclk);
        row_has_exp      = chk;
        row_exp          = exp_word;
        s_valid          = 1'b1;
        s_command        = cmd;
        s_mode_code      = code;
        s_gait_target_m1 = gait[0];
        s_gait_target_m2 = gait[1];
        s_gait_target_m3 = gait[2];
        s_gait_target_m4 = gait[3];
        s_gait_target_m5 = gait[4];
        s_gait_target_m6 = gait[5];
        s_gait_target_m7 = gait[6];
        s_gait_target_m8 = gait[7];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic make_random_word(input int mode_pct, output logic cmd,
                                    output logic [CODE_W-1:0] code, output target_set_t gait);
        if ($urandom_range(0, 99) < mode_pct) begin
            cmd = CMD_MODE;
            case ($urandom_range(0, 7))
                0:       code = MODE_CLR_READY;
                1:       code = MODE_UNLOCK;
                2:       code = MODE_WALK;
                3:       code = MODE_STOP;
                4:       code = MODE_READY;
                5:       code = MODE_PARK;
                default: code = CODE_W'($urandom());
            endcase
        end else begin
            cmd  = CMD_TICK;
            code = CODE_W'($urandom());
        end
        for (int j = 0; j < MAX_MOTORS; j++) begin
            case ($urandom_range(0, 15))
                0:       gait[j] = TGT_MAX;
                1:       gait[j] = TGT_MIN;
                default: gait[j] = TGT_W'($urandom());
            endcase
        end
    endtask

    // Drops valid and waits until every expected result is in, plus the output latency.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        dir_row_t          dir_tab [0:DIR_ROWS-1];
        drive_word_t       exp_word;
        logic              cmd;
        logic [CODE_W-1:0] code;
        target_set_t       gait;
        int                ticks_sent;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_command        = CMD_TICK;
        s_mode_code      = '0;
        s_gait_target_m1 = '0;
        s_gait_target_m2 = '0;
        s_gait_target_m3 = '0;
        s_gait_target_m4 = '0;
        s_gait_target_m5 = '0;
        s_gait_target_m6 = '0;
        s_gait_target_m7 = '0;
        s_gait_target_m8 = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;

        // Locked: flags follow the codes but every target stays at zero.
        dir_tab[0]  = '{CMD_TICK, CODE_IGN_LO,    FILL_MAX,  1'b1, 18'd0,  FL_NONE};
        dir_tab[1]  = '{CMD_TICK, CODE_IGN_HI,    FILL_MIN,  1'b1, 18'd0,  FL_NONE};
        dir_tab[2]  = '{CMD_MODE, MODE_READY,     FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[3]  = '{CMD_TICK, CODE_IGN_LO,    FILL_ZERO, 1'b1, 18'd0,  FL_READY};
        dir_tab[4]  = '{CMD_MODE, MODE_CLR_READY, FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[5]  = '{CMD_TICK, CODE_IGN_LO,    FILL_MAX,  1'b1, 18'd0,  FL_NONE};
        dir_tab[6]  = '{CMD_MODE, MODE_WALK,      FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[7]  = '{CMD_TICK, CODE_IGN_LO,    FILL_MAX,  1'b1, 18'd0,  FL_RUN};
        dir_tab[8]  = '{CMD_MODE, MODE_STOP,      FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[9]  = '{CMD_TICK, CODE_IGN_LO,    FILL_MIN,  1'b1, 18'd0,  FL_STOP};
        dir_tab[10] = '{CMD_MODE, MODE_PARK,      FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[11] = '{CMD_MODE, CODE_IGN_LO,    FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[12] = '{CMD_MODE, CODE_IGN_HI,    FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[13] = '{CMD_TICK, CODE_IGN_LO,    FILL_MAX,  1'b1, 18'd0,  FL_PARK};
        // Unlocked: the stand-up ramp moves by the default step on every tick.
        dir_tab[14] = '{CMD_MODE, MODE_UNLOCK,    FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[15] = '{CMD_TICK, CODE_IGN_LO,    FILL_MAX,  1'b1, 18'd4,  FL_UNLOCK};
        dir_tab[16] = '{CMD_MODE, MODE_READY,     FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[17] = '{CMD_TICK, CODE_IGN_LO,    FILL_ZERO, 1'b1, 18'd8,  FL_UNLOCK | FL_READY};
        dir_tab[18] = '{CMD_MODE, MODE_UNLOCK,    FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[19] = '{CMD_TICK, CODE_IGN_LO,    FILL_MIN,  1'b1, 18'd12, FL_UNLOCK};
        dir_tab[20] = '{CMD_TICK, MODE_UNLOCK,    FILL_MAX,  1'b1, 18'd16, FL_UNLOCK};
        dir_tab[21] = '{CMD_MODE, MODE_PARK,      FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[22] = '{CMD_TICK, CODE_IGN_HI,    FILL_MIN,  1'b1, 18'd20, FL_UNLOCK | FL_PARK};
        dir_tab[23] = '{CMD_MODE, MODE_STOP,      FILL_RAND, 1'b0, 18'd0,  FL_NONE};
        dir_tab[24] = '{CMD_TICK, CODE_IGN_LO,    FILL_MAX,  1'b1, 18'd24, FL_UNLOCK | FL_STOP};

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        tx_idle = 1;
        rx_idle = 1;
        for (int i = 0; i < DIR_ROWS; i++) begin
            case (dir_tab[i].fill)
                FILL_ZERO: gait = '0;
                FILL_MAX:  gait = {MAX_MOTORS{TGT_MAX}};
                FILL_MIN:  gait = {MAX_MOTORS{TGT_MIN}};
                default:   for (int j = 0; j < MAX_MOTORS; j++) gait[j] = TGT_W'($urandom());
            endcase
            for (int j = 0; j < MAX_MOTORS; j++)
                exp_word.drive[j] = (j % 2) ? dir_tab[i].mag : -dir_tab[i].mag;
            exp_word.flags = dir_tab[i].flags;
            exp_word.phase = PH_STAND;
            push_word(dir_tab[i].cmd, dir_tab[i].code, gait, dir_tab[i].chk, exp_word);
        end

        // Stand-up ramp at the largest step under a ramp length too long to end it.
        settle();
        tx_idle = 0;
        rx_idle = 0;
        write_reg(CFG_RAMP_STEP, {13'($urandom()), 4'hF});
        write_reg(CFG_RAMP_LEN, 17'h1FFFF);
        ticks_sent = 0;
        while (ticks_sent < SWEEP_TICKS) begin
            make_random_word(10, cmd, code, gait);
            push_word(cmd, code, gait, 0, '0);
            if (cmd == CMD_TICK) ticks_sent++;
        end

        // Shrinking the ramp length to zero ends the stand-up on the next tick.
        push_word(CMD_MODE, MODE_WALK, '0, 0, '0);
        settle();
        write_reg(CFG_RAMP_LEN, '0);
        for (int i = 0; i < 3; i++) begin
            make_random_word(0, cmd, code, gait);
            push_word(cmd, code, gait, 0, '0);
        end

        tx_idle = 1;
        rx_idle = 1;
        for (int seg = 0; seg < 4; seg++) begin
            settle();
            case (seg)
                0: begin
                    write_reg(CFG_RAMP_STEP, {13'($urandom()), 4'hF});
                    write_reg(CFG_RAMP_LEN, 17'h1FFFF);
                    write_reg(CFG_HOLD_POS, 17'h1FFFF);
                end
                1: begin
                    write_reg(CFG_RAMP_STEP, '0);
                    write_reg(CFG_HOLD_POS, '0);
                    write_reg(CFG_SPARE, CFG_DAT_W'($urandom()));
                end
                2: begin
                    write_reg(CFG_RAMP_STEP, CFG_DAT_W'(1));
                    write_reg(CFG_RAMP_LEN, CFG_DAT_W'(60000));
                    write_reg(CFG_HOLD_POS, CFG_DAT_W'($urandom()));
                end
                default: begin
                    write_reg(CFG_RAMP_STEP, {13'($urandom()), 4'($urandom_range(1, 15))});
                    write_reg(CFG_RAMP_LEN, CFG_DAT_W'(65535));
                    write_reg(CFG_HOLD_POS, CFG_DAT_W'($urandom()));
                end
            endcase
            for (int k = 0; k < SEG_WORDS; k++) begin
                if (k == SEG_WORDS / 2) begin
                    if (seg == 2) settle();
                    if (seg == 3) hold_off_req = 1;
                end
                make_random_word(30, cmd, code, gait);
                push_word(cmd, code, gait, 0, '0);
            end
        end

        // Final stretch without idling: a one-tick park ramp, then the parked phase.
        settle();
        tx_idle = 0;
        rx_idle = 0;
        write_reg(CFG_RAMP_LEN, CFG_DAT_W'(1));
        push_word(CMD_MODE, MODE_PARK, '0, 0, '0);
        for (int i = 0; i < 3; i++) begin
            make_random_word(0, cmd, code, gait);
            push_word(cmd, code, gait, 0, '0);
        end
        for (int i = 0; i < TAIL_WORDS; i++) begin
            make_random_word(40, cmd, code, gait);
            push_word(cmd, code, gait, 0, '0);
        end
        settle();

        $display("Ran %0d mode words and %0d ticks through stand-up, active and parked phases",
                 mode_words, tick_words);
        $display("under several register settings; %0d result words checked, %0d mismatches.",
                 results_seen, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
